/* rtl/mbr_pkg.sv */
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared constants, types and helpers for the minimum barrier raster pass.
// ----------------------------------------------------------------------------
package mbr_pkg;

    localparam int FEAT_W       = 8;
    localparam int DIST_W       = 17;
    localparam int BND_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 10;
    localparam int SIZE_W       = 13;
    localparam int MAX_SIZE_DEF = 512;
    localparam int QUEUE_DEPTH  = 2;
    localparam int MIN_SIZE     = 3;

    localparam logic [CFG_IDX_W-1:0]  REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET       = 10'd512;

    typedef struct packed {
        logic interior;
        logic frame_end;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);
    // feature, dist, lower, upper, control; the column index sits above these
    localparam int PIX_W = FEAT_W + DIST_W + 2 * BND_W + CTL_W;

    // last index in use: size clamped to [MIN_SIZE, hi], minus one
    function automatic logic [SIZE_W-1:0] f_last_index(
        input logic [CFG_DATA_W-1:0] v,
        input logic [SIZE_W-1:0]     hi
    );
        logic [SIZE_W-1:0] ve;
        ve = SIZE_W'(v);
        if (ve < SIZE_W'(MIN_SIZE)) begin
            return SIZE_W'(MIN_SIZE - 1);
        end else if (ve > hi) begin
            return hi - SIZE_W'(1);
        end else begin
            return ve - SIZE_W'(1);
        end
    endfunction

endpackage

/* rtl/mbr_ram.sv */
// ----------------------------------------------------------------------------
// mbr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mbr_front.sv */
// ----------------------------------------------------------------------------
// mbr_front
// Size registers, scan position tracking and pixel classification.
// ----------------------------------------------------------------------------
module mbr_front
    import mbr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_SIZE_DEF,
    parameter int MAX_HEIGHT = MAX_SIZE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data,
    input  logic                                  i_valid,
    input  logic [PIX_W-CTL_W-1:0]                i_data,
    output logic                                  o_ready,
    input  logic                                  i_full,
    output logic                                  o_push,
    output logic [PIX_W+$clog2(MAX_WIDTH)-1:0]    o_push_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] MAXW = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAXH = SIZE_W'(MAX_HEIGHT);

    logic [SIZE_W-1:0] r_col_last;
    logic [SIZE_W-1:0] r_row_last;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic              accept;
    logic              last_col;
    logic              last_row;
    t_ctl              ctl;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign last_col = SIZE_W'(r_col) >= r_col_last;
    assign last_row = SIZE_W'(r_row) >= r_row_last;

    always_comb begin
        ctl.frame_end = last_row && last_col;
        ctl.interior  = !(r_row == '0 || last_row || r_col == '0 || last_col);
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= f_last_index(SIZE_RESET, MAXW);
            r_row_last <= f_last_index(SIZE_RESET, MAXH);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FRAME_WIDTH:  r_col_last <= f_last_index(i_cfg_data, MAXW);
                    REG_FRAME_HEIGHT: r_row_last <= f_last_index(i_cfg_data, MAXH);
                    default: ;
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    assign o_push      = accept;
    assign o_push_data = {r_col, ctl, i_data};

endmodule

/* rtl/mbr_queue.sv */
// ----------------------------------------------------------------------------
// mbr_queue
// Short register FIFO between the classifier and the update datapath.
// ----------------------------------------------------------------------------
module mbr_queue
    import mbr_pkg::*;
#(
    parameter int WIDTH = PIX_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mbr_back.sv */
// ----------------------------------------------------------------------------
// mbr_back
// Line buffer lookup, barrier cost compare and bound update, output register.
// ----------------------------------------------------------------------------
module mbr_back
    import mbr_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  logic [PIX_W+$clog2(MAX_WIDTH)-1:0]  i_q_data,
    output logic                                o_q_pop,
    output logic                                o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_rd_addr,
    input  logic [2*BND_W-1:0]                  i_rd_data,
    output logic                                o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_wr_addr,
    output logic [2*BND_W-1:0]                  o_wr_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [DIST_W-1:0]                   o_dist,
    output logic [BND_W-1:0]                    o_lower,
    output logic [BND_W-1:0]                    o_upper,
    output logic                                o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                  r_a_valid;
    logic [PIX_W+CW-1:0]   r_a;
    logic                  load_a;
    logic                  adv;

    logic [BND_W-1:0]      r_left_lo;
    logic [BND_W-1:0]      r_left_hi;

    logic                  r_o_valid;
    logic [DIST_W-1:0]     r_o_dist;
    logic [BND_W-1:0]      r_o_lo;
    logic [BND_W-1:0]      r_o_hi;
    logic                  r_o_end;

    logic [FEAT_W-1:0]     f;
    logic [DIST_W-1:0]     d_in;
    logic [BND_W-1:0]      lo_in;
    logic [BND_W-1:0]      hi_in;
    t_ctl                  ctl;
    logic [CW-1:0]         col;
    logic [BND_W-1:0]      al, au;
    logic [BND_W-1:0]      l_min, l_max, u_min, u_max;
    logic [BND_W-1:0]      cost_l, cost_u;
    logic [DIST_W-1:0]     d1;
    logic [DIST_W-1:0]     n_dist;
    logic [BND_W-1:0]      n_lo, n_hi;
    logic                  win_l, win_u;

    assign adv     = r_a_valid && (!r_o_valid || i_ready);
    assign load_a  = !r_a_valid || adv;
    assign o_q_pop = i_q_valid && load_a;

    assign o_rd_en   = o_q_pop;
    assign o_rd_addr = i_q_data[PIX_W +: CW];

    assign f     = r_a[0 +: FEAT_W];
    assign d_in  = r_a[FEAT_W +: DIST_W];
    assign lo_in = r_a[FEAT_W+DIST_W +: BND_W];
    assign hi_in = r_a[FEAT_W+DIST_W+BND_W +: BND_W];
    assign ctl   = r_a[FEAT_W+DIST_W+2*BND_W +: CTL_W];
    assign col   = r_a[PIX_W +: CW];
    assign al    = i_rd_data[0 +: BND_W];
    assign au    = i_rd_data[BND_W +: BND_W];

    always_comb begin
        l_min  = (f < r_left_lo) ? f : r_left_lo;
        l_max  = (f > r_left_hi) ? f : r_left_hi;
        u_min  = (f < al) ? f : al;
        u_max  = (f > au) ? f : au;
        cost_l = l_max - l_min;
        cost_u = u_max - u_min;
        win_l  = ctl.interior && (DIST_W'(cost_l) < d_in);
        d1     = win_l ? DIST_W'(cost_l) : d_in;
        win_u  = ctl.interior && (DIST_W'(cost_u) < d1);
        n_dist = win_u ? DIST_W'(cost_u) : d1;
        if (win_u) begin
            n_lo = u_min;
            n_hi = u_max;
        end else if (win_l) begin
            n_lo = l_min;
            n_hi = l_max;
        end else begin
            n_lo = lo_in;
            n_hi = hi_in;
        end
    end

    assign o_wr_en   = adv;
    assign o_wr_addr = col;
    assign o_wr_data = {n_hi, n_lo};

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a <= i_q_data;
        end
        if (adv) begin
            r_left_lo <= n_lo;
            r_left_hi <= n_hi;
            r_o_dist  <= n_dist;
            r_o_lo    <= n_lo;
            r_o_hi    <= n_hi;
            r_o_end   <= ctl.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (load_a) begin
                r_a_valid <= i_q_valid;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_dist      = r_o_dist;
    assign o_lower     = r_o_lo;
    assign o_upper     = r_o_hi;
    assign o_frame_end = r_o_end;

endmodule

/* rtl/minimum_barrier_raster_pass.sv */
// ----------------------------------------------------------------------------
// minimum_barrier_raster_pass
// One raster pass of the minimum barrier distance transform, one channel.
// ----------------------------------------------------------------------------
// Pixels enter on s_axis in scan order, each with its distance and bounds,
// and leave on m_axis in the same order, one result per pixel; tlast marks
// the last pixel of the frame. Frame size is set through the write port
// (index 0 width, index 1 height, clamped to 3..MAX); the user must do so
// only while the block is idle, which the block does not enforce. Throughput:
// one pixel per cycle while m_axis_tready is high; the left-neighbor bound
// loop closes in the update stage, and the row above comes from a MAX_WIDTH
// x 16 line buffer RAM with one read and one write port.
// A two-entry queue sits between the classifier and the update stage, and
// the output register holds a result until the receiver takes it; when
// m_axis_tready is low the pipe fills and s_axis_tready drops.
// Reset clears the scan position, restores 512 x 512 (clamped to MAX) and
// empties the pipe. The line buffer is not cleared: each row reads only
// columns written by the row before.
// ----------------------------------------------------------------------------
module minimum_barrier_raster_pass
    import mbr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_SIZE_DEF,
    parameter int MAX_HEIGHT = MAX_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // feature[7:0], dist_in[24:8], lower_in[32:25], upper_in[40:33], zero pad
    input  logic [47:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // dist_out[16:0], lower_out[24:17], upper_out[32:25], zero pad
    output logic [39:0]           m_axis_tdata,
    // frame_end
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = PIX_W + CW;

    logic              push;
    logic [QW-1:0]     push_data;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_data;
    logic              ram_re;
    logic [CW-1:0]     ram_raddr;
    logic [2*BND_W-1:0] ram_rdata;
    logic              ram_we;
    logic [CW-1:0]     ram_waddr;
    logic [2*BND_W-1:0] ram_wdata;
    logic [DIST_W-1:0] dist_out;
    logic [BND_W-1:0]  lower_out;
    logic [BND_W-1:0]  upper_out;

    mbr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_data      (s_axis_tdata[PIX_W-CTL_W-1:0]),
        .o_ready     (s_axis_tready),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mbr_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    mbr_ram #(
        .WIDTH (2 * BND_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    mbr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_rd_en     (ram_re),
        .o_rd_addr   (ram_raddr),
        .i_rd_data   (ram_rdata),
        .o_wr_en     (ram_we),
        .o_wr_addr   (ram_waddr),
        .o_wr_data   (ram_wdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_dist      (dist_out),
        .o_lower     (lower_out),
        .o_upper     (upper_out),
        .o_frame_end (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, upper_out, lower_out, dist_out};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_ram_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
        else $error("line buffer read and write at same column");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> !push)
        else $error("push while queue full");

endmodule

/* tb/minimum_barrier_raster_pass_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimum_barrier_raster_pass_test
// Self-checking bench for one raster pass of the minimum barrier transform.
// ----------------------------------------------------------------------------
// A short scripted sequence covers reset size, clamped sizes, a mid-row size
// change, pass-through borders and the left/up/neither/tie update cases. A
// wide first row at the clamped maximum width follows, with a long output
// stall. Then come random frames of small sizes, with size changes at idle
// points, most of them mid-frame. Every pixel taken on s_axis goes through a
// local copy of the pass; results on m_axis are compared in order.
// ----------------------------------------------------------------------------
module minimum_barrier_raster_pass_test;
    import mbr_pkg::*;

    localparam int          MAX_W         = MAX_SIZE_DEF;
    localparam int          MAX_H         = MAX_SIZE_DEF;
    localparam int unsigned RANDOM_PIXELS = 1420;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned MAX_PRINTS    = 30;

    typedef struct packed {
        logic [BND_W-1:0]  upper;
        logic [BND_W-1:0]  lower;
        logic [DIST_W-1:0] distance;
        logic [FEAT_W-1:0] feature;
    } pixel_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [BND_W-1:0]  lower;
        logic [BND_W-1:0]  upper;
        logic              last;
    } barrier_t;

    typedef struct {
        bit known;
        bit last;
    } vouch_t;

    typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_e;

    typedef struct {
        step_kind_e            kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        pixel_t                px;
        bit                    known;
        bit                    last;
    } step_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    minimum_barrier_raster_pass dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the pass
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int unsigned           scan_col;
    int unsigned           scan_row;
    int unsigned           row_len_above;
    logic [15:0]           bound_line [MAX_W];
    logic [BND_W-1:0]      left_lo;
    logic [BND_W-1:0]      left_hi;

    barrier_t    barrier_q [$];
    vouch_t      vouched_q [$];
    step_t       script [$];

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_seen   = 0;
    int unsigned pixels_in     = 0;
    int unsigned pixels_sent   = 0;
    int unsigned size_writes   = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_idle      = 7;
    int unsigned sink_idle     = 70;
    int unsigned hold_reqs     = 0;
    int unsigned holds_taken   = 0;
    int unsigned hold_left     = 0;
    logic [7:0]  feat_trail    = 8'd128;

    function automatic int unsigned size_in_use(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [7:0] smaller(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] larger(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    // one pixel through the pass; advances the scan position
    function automatic barrier_t barrier_update(input pixel_t p);
        int unsigned w, h, col;
        bit          last_c, last_r;
        logic [7:0]  a_lo, a_hi, lo, hi, cost_l, cost_u;
        logic [DIST_W-1:0] d;
        barrier_t    res;
        w = size_in_use(width_reg, MAX_W);
        h = size_in_use(height_reg, MAX_H);
        last_c = scan_col >= w - 1;
        last_r = scan_row >= h - 1;
        col = (scan_col < MAX_W) ? scan_col : MAX_W - 1;
        d = p.distance;
        lo = p.lower;
        hi = p.upper;
        if (scan_row != 0 && !last_r && scan_col != 0 && !last_c) begin
            a_lo = bound_line[col][7:0];
            a_hi = bound_line[col][15:8];
            cost_l = larger(p.feature, left_hi) - smaller(p.feature, left_lo);
            cost_u = larger(p.feature, a_hi) - smaller(p.feature, a_lo);
            if (DIST_W'(cost_l) < d) begin
                d = DIST_W'(cost_l);
                lo = smaller(p.feature, left_lo);
                hi = larger(p.feature, left_hi);
            end
            if (DIST_W'(cost_u) < d) begin
                d = DIST_W'(cost_u);
                lo = smaller(p.feature, a_lo);
                hi = larger(p.feature, a_hi);
            end
        end
        bound_line[col] = {hi, lo};
        left_lo = lo;
        left_hi = hi;
        res.distance = d;
        res.lower = lo;
        res.upper = hi;
        res.last = last_r && last_c;
        if (last_c) begin
            row_len_above = scan_col + 1;
            scan_col = 0;
            scan_row = last_r ? 0 : scan_row + 1;
        end else begin
            scan_col = scan_col + 1;
        end
        return res;
    endfunction

    // input side: register writes and accepted pixels feed the local pass
    always @(posedge i_clk) begin : track_in
        pixel_t   got;
        barrier_t want;
        vouch_t   note;
        if (!i_rst_n) begin
            width_reg = SIZE_RESET;
            height_reg = SIZE_RESET;
            scan_col = 0;
            scan_row = 0;
            row_len_above = 0;
            left_lo = '0;
            left_hi = '0;
            foreach (bound_line[k]) bound_line[k] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_FRAME_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_addr == REG_FRAME_HEIGHT) height_reg = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got = s_axis_tdata[$bits(pixel_t)-1:0];
                want = barrier_update(got);
                note = vouched_q.pop_front();
                if (note.known) begin
                    want.distance = got.distance;
                    want.lower = got.lower;
                    want.upper = got.upper;
                    want.last = note.last;
                end
                barrier_q.push_back(want);
                pixels_in++;
            end
        end
    end

    task automatic flag(input string what, input int unsigned got, input int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_out
        barrier_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (barrier_q.size() == 0) begin
                flag("unexpected transfer, dist", m_axis_tdata[16:0], 0);
            end else begin
                want = barrier_q.pop_front();
                if (m_axis_tdata[16:0] !== want.distance)
                    flag("dist", m_axis_tdata[16:0], want.distance);
                if (m_axis_tdata[24:17] !== want.lower)
                    flag("lower", m_axis_tdata[24:17], want.lower);
                if (m_axis_tdata[32:25] !== want.upper)
                    flag("upper", m_axis_tdata[32:25], want.upper);
                if (m_axis_tlast !== want.last) flag("frame_end", m_axis_tlast, want.last);
                if (m_axis_tdata[39:33] !== '0) flag("pad", m_axis_tdata[39:33], 0);
            end
            results_seen++;
            if (m_axis_tlast) frames_seen++;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_reqs != holds_taken) begin
            holds_taken = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     barrier_q.size());
            $display("minimum_barrier_raster_pass_test: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(input pixel_t p, input bit known, input bit last);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        vouched_q.push_back('{known: known, last: last});
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 48'(p);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        while (barrier_q.size() != 0 || vouched_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        size_writes++;
    endtask

    function automatic step_t pix(input int f, input int d, input int lo, input int hi,
                                  input bit known, input bit last);
        step_t s;
        s.kind = STEP_PIXEL;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.px.feature = f[7:0];
        s.px.distance = d[16:0];
        s.px.lower = lo[7:0];
        s.px.upper = hi[7:0];
        s.known = known;
        s.last = last;
        return s;
    endfunction

    function automatic step_t setreg(input logic [CFG_IDX_W-1:0] idx, input int v);
        step_t s;
        s = pix(0, 0, 0, 0, 1'b0, 1'b0);
        s.kind = STEP_WRITE;
        s.reg_idx = idx;
        s.reg_val = v[CFG_DATA_W-1:0];
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        if ($urandom_range(99) < 4) return CFG_DATA_W'($urandom_range(1023));
        return CFG_DATA_W'($urandom_range(12));
    endfunction

    // mostly first-pass or second-pass style content, some noise
    function automatic pixel_t make_pixel(input bit border);
        pixel_t      p;
        int unsigned roll;
        int          f, lo, hi;
        roll = $urandom_range(99);
        if (roll < 12) begin
            f = $urandom_range(1) ? 255 : 0;
        end else if (roll < 30) begin
            f = $urandom_range(255);
        end else begin
            f = int'(feat_trail) + int'($urandom_range(16)) - 8;
            if (f < 0) f = 0;
            if (f > 255) f = 255;
        end
        feat_trail = f[7:0];
        p.feature = f[7:0];
        roll = $urandom_range(99);
        if (roll < 15) begin
            p.distance = DIST_W'($urandom_range(131071));
            p.lower = 8'($urandom_range(255));
            p.upper = 8'($urandom_range(255));
        end else if (border || roll < 60) begin
            p.distance = border ? '0 : DIST_W'(100000);
            p.lower = f[7:0];
            p.upper = f[7:0];
        end else begin
            lo = f - int'($urandom_range(f));
            hi = f + int'($urandom_range(255 - f));
            p.distance = DIST_W'(hi - lo);
            p.lower = lo[7:0];
            p.upper = hi[7:0];
        end
        return p;
    endfunction

    task automatic run_phase(input int unsigned n);
        int unsigned w, h, c, r;
        w = size_in_use(width_reg, MAX_W);
        h = size_in_use(height_reg, MAX_H);
        c = scan_col;
        r = scan_row;
        repeat (n) begin
            send_pixel(make_pixel(c == 0 || r == 0 || c >= w - 1 || r >= h - 1), 1'b0, 1'b0);
            pixels_sent++;
            if (c >= w - 1) begin
                c = 0;
                r = (r >= h - 1) ? 0 : r + 1;
            end else begin
                c++;
            end
        end
    endtask

    initial begin
        int unsigned           n_phase;
        int unsigned           stage;
        logic [CFG_DATA_W-1:0] v;
        n_phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two pixels at reset size, then shrink to the clamped minimum mid-row
        script.push_back(pix(0, 0, 0, 0, 1, 0));
        script.push_back(pix(255, 131071, 255, 255, 1, 0));
        script.push_back(setreg(REG_FRAME_WIDTH, 0));
        script.push_back(setreg(REG_FRAME_HEIGHT, 2));
        script.push_back(pix(128, 100000, 0, 255, 1, 0));
        script.push_back(pix(255, 0, 255, 255, 1, 0));
        script.push_back(pix(0, 131071, 0, 0, 0, 0));
        script.push_back(pix(1, 65536, 128, 127, 1, 0));
        script.push_back(pix(0, 131071, 0, 0, 1, 0));
        script.push_back(pix(255, 0, 255, 0, 1, 0));
        script.push_back(pix(17, 99, 3, 200, 1, 1));
        // 4x4: left wins, up wins, neither wins, tie keeps the input
        script.push_back(setreg(REG_FRAME_WIDTH, 4));
        script.push_back(setreg(REG_FRAME_HEIGHT, 4));
        script.push_back(pix(10, 0, 10, 10, 1, 0));
        script.push_back(pix(200, 0, 5, 250, 1, 0));
        script.push_back(pix(0, 0, 0, 0, 1, 0));
        script.push_back(pix(255, 131071, 255, 255, 1, 0));
        script.push_back(pix(50, 0, 40, 60, 1, 0));
        script.push_back(pix(50, 100000, 50, 50, 0, 0));
        script.push_back(pix(0, 100000, 0, 0, 0, 0));
        script.push_back(pix(128, 7, 1, 2, 1, 0));
        script.push_back(pix(255, 0, 255, 255, 1, 0));
        script.push_back(pix(255, 0, 3, 4, 0, 0));
        script.push_back(pix(4, 1, 9, 200, 0, 0));
        script.push_back(pix(0, 131071, 0, 255, 1, 0));
        script.push_back(pix(1, 2, 3, 4, 1, 0));
        script.push_back(pix(255, 131071, 0, 255, 1, 0));
        script.push_back(pix(0, 0, 255, 0, 1, 0));
        script.push_back(pix(77, 100000, 77, 77, 1, 1));

        foreach (script[i]) begin
            if (script[i].kind == STEP_WRITE) begin
                wait_idle(3);
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                send_pixel(script[i].px, script[i].known, script[i].last);
            end
        end

        // one full row at the clamped maximum width, output held off meanwhile
        wait_idle(3);
        write_reg(REG_FRAME_WIDTH, 10'd1023);
        write_reg(REG_FRAME_HEIGHT, 10'd1023);
        hold_reqs <= hold_reqs + 1;
        run_phase(MAX_W);

        while (pixels_sent < RANDOM_PIXELS) begin
            stage = pixels_sent * 3 / RANDOM_PIXELS;
            wait_idle(3);
            src_idle = (stage == 0) ? 7 : (stage == 1) ? 70 : 0;
            sink_idle <= (stage == 0) ? 70 : (stage == 1) ? 7 : 0;
            if ($urandom_range(1)) begin
                v = pick_size();
                // a row may only read columns the row above has written
                if (scan_row != 0 && size_in_use(v, MAX_W) > row_len_above + 1)
                    v = CFG_DATA_W'(row_len_above + 1);
                write_reg(REG_FRAME_WIDTH, v);
            end
            if ($urandom_range(1)) write_reg(REG_FRAME_HEIGHT, pick_size());
            if (n_phase % 9 == 4) hold_reqs <= hold_reqs + 1;
            run_phase($urandom_range(8, 90));
            n_phase++;
        end

        wait_idle(12);
        $display("%0d pixels in, %0d results checked, %0d frames closed", pixels_in,
                 results_seen, frames_seen);
        $display("%0d size writes over %0d random phases, %0d output hold-offs", size_writes,
                 n_phase, holds_taken);
        if (mismatches == 0) begin
            $display("minimum_barrier_raster_pass_test: done, clean");
        end else begin
            $display("minimum_barrier_raster_pass_test: done, errors");
        end
        $finish;
    end

endmodule
